>>> sv/shc_pkg.sv
// Package: shared types, constants and SHA-256 helper functions.
`default_nettype none
package shc_pkg;

  localparam int unsigned HashW  = 256;
  localparam int unsigned CountW = 32;
  localparam int unsigned BalW   = 64;
  localparam int unsigned Rounds = 64;
  localparam int unsigned RndW   = 6;

  typedef enum logic {
    ACT_CLEAR = 1'b0,
    ACT_ADD   = 1'b1
  } action_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;     // empty the accumulator
    logic load;      // capture the input item
    logic take;      // first hash becomes running hash; count and sum update
    logic blk_init;  // start compression of the message block
    logic pad_init;  // fold first compression, start the padding block
    logic round;     // run one round
    logic commit;    // chaining value becomes running hash, count and sum update
  } shc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hash_zero;
    logic count_zero;
    logic is_add;
    logic last_round;
  } shc_sts_t;

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] InitH =
    256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

  // Padding block for a 64-byte message.
  localparam logic [511:0] PadBlk = {32'h80000000, 448'd0, 32'd512};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

>>> sv/shc_ctrl.sv
// Controller: sequences load and, for a chaining add, two compressions and commit.
`default_nettype none
module shc_ctrl import shc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     out_busy_i,
  input  shc_sts_t sts_i,
  output shc_cmd_t cmd_o,
  output logic     in_ready_o,
  output logic     res_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_BLK, S_PAD, S_FOLD2, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = in_fire_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.is_add) begin
          cmd_o.clear = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.hash_zero) begin
          state_d = S_DONE;
        end else if (sts_i.count_zero) begin
          cmd_o.take = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.blk_init = 1'b1;
          state_d = S_BLK;
        end
      end
      S_BLK: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = S_PAD;
      end
      S_PAD: begin
        cmd_o.pad_init = 1'b1;
        state_d = S_FOLD2;
      end
      S_FOLD2: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) begin
          cmd_o.commit = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE) && !out_busy_i;

`ifndef SYNTHESIS
  a_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == S_IDLE) else $error("accept outside idle");
  a_round_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.round |-> (state_q == S_BLK || state_q == S_FOLD2)) else $error("stray round");
  a_one_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.blk_init && cmd_o.pad_init)) else $error("double init");
`endif

endmodule
`default_nettype wire

>>> sv/shc_datapath.sv
// Datapath: input capture, SHA-256 round engine, state registers.
`default_nettype none
module shc_datapath import shc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shc_cmd_t          cmd_i,
  input  logic              action_i,
  input  logic [HashW-1:0]  hash_i,
  input  logic [BalW-1:0]   balance_i,
  output shc_sts_t          sts_o,
  output logic [HashW-1:0]  sum_o,
  output logic [CountW-1:0] count_o,
  output logic [BalW-1:0]   total_o
);

  logic              act_q;
  logic [HashW-1:0]  new_q;
  logic [BalW-1:0]   bal_q;
  logic [HashW-1:0]  run_q;
  logic [CountW-1:0] cnt_q;
  logic [BalW-1:0]   tot_q;
  logic [255:0]      hv_q;     // chaining value
  logic [255:0]      wv_q;     // a..h
  logic [511:0]      sched_q;  // 16-word window, word 0 on top
  logic [RndW-1:0]   rnd_q;

  logic [31:0] a, b, c, d, e, f, g, h, wt, t1, t2, wn;
  logic [255:0] hv_sum;

  always_comb begin
    {a, b, c, d, e, f, g, h} = wv_q;
    wt = sched_q[511 -: 32];
    t1 = h + bsig1(e) + ((e & f) ^ (~e & g)) + RoundK[rnd_q] + wt;
    t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
    wn = sched_q[511 -: 32] + ssig0(sched_q[479 -: 32]) + sched_q[223 -: 32]
       + ssig1(sched_q[63 -: 32]);
    for (int i = 0; i < 8; i++) begin
      hv_sum[i*32 +: 32] = hv_q[i*32 +: 32] + wv_q[i*32 +: 32];
    end
  end

  function automatic logic [255:0] hv_sum_last();
    logic [255:0] nv, r;
    nv = {t1 + t2, a, b, c, d + t1, e, f, g};
    for (int i = 0; i < 8; i++) begin
      r[i*32 +: 32] = hv_q[i*32 +: 32] + nv[i*32 +: 32];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      new_q <= hash_i;
      bal_q <= balance_i;
    end
    if (cmd_i.blk_init) begin
      hv_q    <= InitH;
      wv_q    <= InitH;
      sched_q <= {run_q, new_q};
      rnd_q   <= '0;
    end else if (cmd_i.pad_init) begin
      hv_q    <= hv_sum;
      wv_q    <= hv_sum;
      sched_q <= PadBlk;
      rnd_q   <= '0;
    end else if (cmd_i.round) begin
      wv_q    <= {t1 + t2, a, b, c, d + t1, e, f, g};
      sched_q <= {sched_q[479:0], wn};
      rnd_q   <= rnd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      cnt_q <= '0;
      tot_q <= '0;
    end else if (cmd_i.clear) begin
      run_q <= '0;
      cnt_q <= '0;
      tot_q <= '0;
    end else if (cmd_i.take || cmd_i.commit) begin
      // commit fires with the last round pending; fold it in here
      run_q <= cmd_i.take ? new_q : hv_sum_last();
      cnt_q <= (&cnt_q) ? cnt_q : cnt_q + 1'b1;
      tot_q <= tot_q + bal_q;
    end
  end

  assign sts_o.hash_zero  = (new_q == '0);
  assign sts_o.count_zero = (cnt_q == '0);
  assign sts_o.is_add     = (act_q == ACT_ADD);
  assign sts_o.last_round = (&rnd_q);
  assign sum_o   = run_q;
  assign count_o = cnt_q;
  assign total_o = tot_q;

`ifndef SYNTHESIS
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&cnt_q) && !cmd_i.clear |=> (&cnt_q)) else $error("count left saturation");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (run_q == '0)) else $error("hash set while empty");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (cnt_q == '0 && tot_q == '0)) else $error("clear failed");
`endif

endmodule
`default_nettype wire

>>> sv/sha256_hash_chain_accumulator_top.sv
// Top level: SHA-256 hash chain accumulator with stream ports.
// Each request is handled alone. A clear, a zero-hash add or the first
// nonzero hash goes from accept to result with no compression; a chaining
// add runs on one shared SHA-256 round unit, 64 rounds for the message
// block and 64 for the padding block. A result sits in an output
// register; the next request is accepted as soon as it has been loaded
// there, even while the result waits for m_axis_tready_i.
// Output hash is zero while the entry count is zero.
`default_nettype none
module sha256_hash_chain_accumulator_top import shc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [319:0] s_axis_tdata_i,  // hash_w0, hash_w1, hash_w2, hash_w3, balance
  input  logic         s_axis_tuser_i,  // action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [351:0] m_axis_tdata_o   // sum_w0..sum_w3, entry_count, balance_total
);

  shc_cmd_t cmd;
  shc_sts_t sts;
  logic in_fire, res_valid, out_busy;
  logic [HashW-1:0]  sum;
  logic [CountW-1:0] cnt;
  logic [BalW-1:0]   tot;
  logic         ovalid_q;
  logic [351:0] odata_q;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_busy = ovalid_q && !m_axis_tready_i;

  shc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .out_busy_i(out_busy), .sts_i(sts),
    .cmd_o(cmd), .in_ready_o(s_axis_tready_o), .res_valid_o(res_valid)
  );

  // hash_w0 becomes the top 64 bits of the 256-bit hash
  shc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .action_i(s_axis_tuser_i),
    .hash_i({s_axis_tdata_i[63:0], s_axis_tdata_i[127:64],
             s_axis_tdata_i[191:128], s_axis_tdata_i[255:192]}),
    .balance_i(s_axis_tdata_i[319:256]),
    .sts_o(sts), .sum_o(sum), .count_o(cnt), .total_o(tot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (res_valid) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      odata_q <= {tot, cnt, sum[63:0], sum[127:64], sum[191:128], sum[255:192]};
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output dropped while stalled");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_busy) else $error("result overwrote pending output");
  a_res_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid_o) else $error("result not presented");
`endif

endmodule
`default_nettype wire
